// ===== hdl/itb_pkg.sv =====
// itb_pkg: shared constants, codes and types of the interval timer with backoff
// used by the interfaces, the register file and the top level; no dependencies
`default_nettype none

package itb_pkg;

   // widths of the timer datapath
   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 32;
   localparam int FIELD_BITS = 32;
   localparam int MODE_BITS  = 3;
   localparam int STATE_BITS = 3;

   // register port geometry
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_IDX_BITS  = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_FIRST_INTERVAL  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PERIOD          = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_EXPIRATIONS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BACKOFF_ENABLE  = 2'd3;

   // item modes
   localparam logic [MODE_BITS-1:0] MD_TICK       = 3'd0;
   localparam logic [MODE_BITS-1:0] MD_START      = 3'd1;
   localparam logic [MODE_BITS-1:0] MD_PAUSE      = 3'd2;
   localparam logic [MODE_BITS-1:0] MD_RESUME     = 3'd3;
   localparam logic [MODE_BITS-1:0] MD_CANCEL     = 3'd4;
   localparam logic [MODE_BITS-1:0] MD_RESTART    = 3'd5;
   localparam logic [MODE_BITS-1:0] MD_RESCHEDULE = 3'd6;

   // timer phases
   localparam logic [STATE_BITS-1:0] PH_INIT   = 3'd0;
   localparam logic [STATE_BITS-1:0] PH_RUN    = 3'd1;
   localparam logic [STATE_BITS-1:0] PH_PAUSE  = 3'd2;
   localparam logic [STATE_BITS-1:0] PH_RESUME = 3'd3;
   localparam logic [STATE_BITS-1:0] PH_CANCEL = 3'd4;

   // configuration as seen by the timer
   typedef struct packed {
      logic [FIELD_BITS-1:0] first_interval;
      logic [FIELD_BITS-1:0] period;
      logic [FIELD_BITS-1:0] max_expirations;
      logic                  backoff_enable;
   } itb_cfg_type;

endpackage

`default_nettype wire

// ===== hdl/itb_req_if.sv =====
// itb_req_if: valid/ready channel carrying tick and command items
// depends on itb_pkg
`default_nettype none

interface itb_req_if;
   import itb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [FIELD_BITS-1:0] new_first;
   logic [FIELD_BITS-1:0] new_period;

   modport source (output valid, output mode, output new_first, output new_period,
                   input ready);
   modport sink   (input valid, input mode, input new_first, input new_period,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/itb_rsp_if.sv =====
// itb_rsp_if: valid/ready channel carrying timer status items
// depends on itb_pkg
`default_nettype none

interface itb_rsp_if;
   import itb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  expired;
   logic [STATE_BITS-1:0] run_state;
   logic [FIELD_BITS-1:0] expiry_count;
   logic [FIELD_BITS-1:0] time_left;

   modport source (output valid, output expired, output run_state,
                   output expiry_count, output time_left, input ready);
   modport sink   (input valid, input expired, input run_state,
                   input expiry_count, input time_left, output ready);
endinterface

`default_nettype wire

// ===== hdl/interval_timer_with_backoff.sv =====
// interval_timer_with_backoff: top level, timer state update and result register
// depends on itb_pkg, itb_req_if, itb_rsp_if and itb_csr
`default_nettype none

// Interval timer driven by tick items (one per millisecond) and command items
// (start, pause, resume, cancel, restart, reschedule). Every item produces one
// status item that reports the state after that item. One item is accepted
// every clock cycle; its status appears in the following cycle from the result
// register. The single result register sets the rate: when the consumer holds
// rsp.ready low with a status waiting, req.ready drops until it is taken.
// Configuration must be written through the APB port at byte addresses 0x0
// (first_interval), 0x4 (period), 0x8 (max_expirations) and 0xC (backoff_enable,
// bit 0) while the timer sees no traffic; the block itself does not enforce it.

module interval_timer_with_backoff (
   input  wire logic                               clock,
   input  wire logic                               reset,
   itb_req_if.sink                                 req,
   itb_rsp_if.source                               rsp,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [itb_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [itb_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [itb_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                    pready
);
   import itb_pkg::*;

   itb_cfg_type cfg;

   // timer state
   logic [STATE_BITS-1:0] phase_ff,     phase_in;
   logic [TIME_BITS-1:0]  countdown_ff, countdown_in;
   logic [TIME_BITS-1:0]  reload_ff,    reload_in;
   logic [COUNT_BITS-1:0] expir_ff,     expir_in;
   logic [TIME_BITS-1:0]  backoff_ff,   backoff_in;
   logic [TIME_BITS-1:0]  saved_ff,     saved_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  expired_ff,   expired_in;
   logic [STATE_BITS-1:0] state_out_ff;
   logic [FIELD_BITS-1:0] count_out_ff, count_out_in;
   logic [FIELD_BITS-1:0] left_out_ff,  left_out_in;

   logic                  accept;
   logic [TIME_BITS-1:0]  cfg_first;
   logic [TIME_BITS-1:0]  cfg_period;
   logic [TIME_BITS-1:0]  cd_dec;
   logic [COUNT_BITS-1:0] expir_inc;
   logic                  over_limit;
   logic [TIME_BITS-1:0]  backoff_dbl;
   logic [STATE_BITS-1:0] phase_fire;

   itb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake: the result register frees up when its item is taken
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // operands shared by the commands
   assign cfg_first   = TIME_BITS'(cfg.first_interval);
   assign cfg_period  = TIME_BITS'(cfg.period);
   assign cd_dec      = countdown_ff - 1'b1;
   assign expir_inc   = (&expir_ff) ? expir_ff : expir_ff + 1'b1;
   assign over_limit  = (cfg.max_expirations != '0) &&
                        (FIELD_BITS'(expir_inc) > cfg.max_expirations);
   assign backoff_dbl = backoff_ff[TIME_BITS-1] ? '1 : {backoff_ff[TIME_BITS-2:0], 1'b0};
   assign phase_fire  = (phase_ff == PH_RESUME && cfg_period != '0) ? PH_RUN : phase_ff;

   // next state for one item
   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      reload_in    = reload_ff;
      expir_in     = expir_ff;
      backoff_in   = backoff_ff;
      saved_in     = saved_ff;
      expired_in   = 1'b0;
      case (req.mode)
         MD_TICK: begin
            if (countdown_ff != '0) begin
               countdown_in = cd_dec;
               if (cd_dec == '0) begin
                  expir_in = expir_inc;
                  if (over_limit) begin
                     // limit passed: no firing; cancel unless still in the init phase
                     if (phase_ff != PH_INIT) begin
                        reload_in = '0;
                        saved_in  = '0;
                        expir_in  = '0;
                        phase_in  = PH_CANCEL;
                     end
                  end else begin
                     expired_in = 1'b1;
                     phase_in   = phase_fire;
                     if (cfg.backoff_enable) begin
                        countdown_in = backoff_dbl;
                        reload_in    = '0;
                        backoff_in   = backoff_dbl;
                        saved_in     = '0;
                        phase_in     = PH_RUN;
                     end else if (phase_fire == PH_RESUME) begin
                        countdown_in = cfg_first;
                        reload_in    = cfg_period;
                        saved_in     = '0;
                        phase_in     = PH_RUN;
                     end else begin
                        countdown_in = reload_ff;
                     end
                  end
               end
            end
         end
         MD_START: begin
            countdown_in = cfg_first;
            reload_in    = cfg.backoff_enable ? '0 : cfg_period;
            backoff_in   = cfg_first;
            phase_in     = PH_RUN;
         end
         MD_PAUSE: begin
            if (phase_ff != PH_PAUSE) begin
               saved_in     = (phase_ff == PH_CANCEL) ? '1 : countdown_ff;
               countdown_in = '0;
               reload_in    = '0;
               phase_in     = PH_PAUSE;
            end
         end
         MD_RESUME: begin
            if (phase_ff == PH_PAUSE) begin
               countdown_in = saved_ff;
               reload_in    = cfg_period;
               saved_in     = '0;
               phase_in     = PH_RESUME;
            end
         end
         MD_CANCEL: begin
            if (phase_ff != PH_INIT) begin
               countdown_in = '0;
               reload_in    = '0;
               saved_in     = '0;
               expir_in     = '0;
               phase_in     = PH_CANCEL;
            end
         end
         MD_RESTART: begin
            countdown_in = cfg_first;
            reload_in    = cfg.backoff_enable ? '0 : cfg_period;
            expir_in     = '0;
            saved_in     = '0;
            backoff_in   = cfg_first;
            phase_in     = PH_RUN;
         end
         MD_RESCHEDULE: begin
            countdown_in = TIME_BITS'(req.new_first);
            if (cfg.backoff_enable) begin
               reload_in  = '0;
               backoff_in = TIME_BITS'(req.new_first);
            end else begin
               reload_in  = TIME_BITS'(req.new_period);
            end
            saved_in = '0;
            phase_in = PH_RUN;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // status fields from the updated state
   assign count_out_in = FIELD_BITS'(expir_in);
   assign left_out_in  = (phase_in == PH_CANCEL) ? '1 : FIELD_BITS'(countdown_in);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_INIT;
         countdown_ff <= '0;
         reload_ff    <= '0;
         expir_ff     <= '0;
         backoff_ff   <= '0;
         saved_ff     <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         reload_ff    <= reload_in;
         expir_ff     <= expir_in;
         backoff_ff   <= backoff_in;
         saved_ff     <= saved_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         expired_ff   <= expired_in;
         state_out_ff <= phase_in;
         count_out_ff <= count_out_in;
         left_out_ff  <= left_out_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.expired      = expired_ff;
   assign rsp.run_state    = state_out_ff;
   assign rsp.expiry_count = count_out_ff;
   assign rsp.time_left    = left_out_ff;

`ifndef SYNTH
   // a cancelled timer is always disarmed
   a_cancel_disarmed: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CANCEL |-> countdown_ff == '0)
      else $error("cancelled timer still armed");

   // a paused timer has nothing to reload
   a_pause_no_reload: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAUSE |-> (countdown_ff == '0 && reload_ff == '0))
      else $error("paused timer still armed");

   // only a tick can fire
   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && req.mode != MD_TICK) |=> !expired_ff)
      else $error("expiry reported for a command item");

   // every accepted item leaves a status waiting
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no status");
`endif

endmodule

`default_nettype wire

// ===== hdl/itb_csr.sv =====
// itb_csr: APB register file holding the timer configuration
// depends on itb_pkg
`default_nettype none

module itb_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [itb_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [itb_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [itb_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                    pready,
   output itb_pkg::itb_cfg_type                    cfg
);
   import itb_pkg::*;

   itb_cfg_type             cfg_ff;
   itb_cfg_type             cfg_in;
   logic                    wr_en;
   logic [CSR_IDX_BITS-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_IDX_BITS+1:2];

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FIRST_INTERVAL:  cfg_in.first_interval  = pwdata;
            REG_PERIOD:          cfg_in.period          = pwdata;
            REG_MAX_EXPIRATIONS: cfg_in.max_expirations = pwdata;
            REG_BACKOFF_ENABLE:  cfg_in.backoff_enable  = pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_FIRST_INTERVAL:  prdata = cfg_ff.first_interval;
         REG_PERIOD:          prdata = cfg_ff.period;
         REG_MAX_EXPIRATIONS: prdata = cfg_ff.max_expirations;
         REG_BACKOFF_ENABLE:  prdata = {{(CSR_DATA_BITS-1){1'b0}}, cfg_ff.backoff_enable};
         default:             prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire
